// File: src/eimc_pkg.sv
package eimc_pkg;

    localparam int PC_WIDTH_DEFAULT = 14;
    localparam int NEXT_PC_W        = 14;
    localparam int RF_DEPTH         = 32;
    localparam int RF_ADDR_W        = 5;
    localparam int DATA_W           = 8;
    localparam int INSTR_W          = 16;

    localparam logic [INSTR_W-1:0] MASK_TOP4 = 16'hF000;
    localparam logic [INSTR_W-1:0] MASK_ALU  = 16'hFC00;
    localparam logic [INSTR_W-1:0] MASK_BR   = 16'hF807;
    localparam logic [INSTR_W-1:0] PAT_LDI   = 16'hE000;
    localparam logic [INSTR_W-1:0] PAT_ADD   = 16'h0C00;
    localparam logic [INSTR_W-1:0] PAT_CP    = 16'h1400;
    localparam logic [INSTR_W-1:0] PAT_RJMP  = 16'hC000;
    localparam logic [INSTR_W-1:0] PAT_BR    = 16'hF001;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;
    localparam int FLAG_S = 4;
    localparam int FLAG_H = 5;

    typedef struct packed {
        logic [INSTR_W-1:0] instruction;
    } t_in_item;

    typedef struct packed {
        logic [NEXT_PC_W-1:0] next_pc;
        logic [DATA_W-1:0]    status_flags;
        logic [RF_ADDR_W-1:0] write_index;
        logic [DATA_W-1:0]    write_data;
        logic                 write_done;
        logic                 branch_taken;
        logic                 unknown_opcode;
    } t_out_item;

endpackage

// File: src/eimc_chan_if.sv
interface eimc_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/eimc_regfile.sv
module eimc_regfile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [eimc_pkg::RF_ADDR_W-1:0]  i_addr_a,
    input  logic [eimc_pkg::RF_ADDR_W-1:0]  i_addr_b,
    input  logic                            i_we,
    input  logic [eimc_pkg::RF_ADDR_W-1:0]  i_waddr,
    input  logic [eimc_pkg::DATA_W-1:0]     i_wdata,
    output logic [eimc_pkg::DATA_W-1:0]     o_data_a,
    output logic [eimc_pkg::DATA_W-1:0]     o_data_b
);

    logic [eimc_pkg::DATA_W-1:0] r_mem [eimc_pkg::RF_DEPTH];
    logic [eimc_pkg::RF_DEPTH-1:0] r_valid;
    logic [eimc_pkg::DATA_W-1:0] r_qa;
    logic [eimc_pkg::DATA_W-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // A write in the same cycle as a read of that entry is bypassed.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            if (i_we && i_waddr == i_addr_a) begin
                r_qa <= i_wdata;
            end else if (r_valid[i_addr_a]) begin
                r_qa <= r_mem[i_addr_a];
            end else begin
                r_qa <= '0;
            end
            if (i_we && i_waddr == i_addr_b) begin
                r_qb <= i_wdata;
            end else if (r_valid[i_addr_b]) begin
                r_qb <= r_mem[i_addr_b];
            end else begin
                r_qb <= '0;
            end
        end
    end

    assign o_data_a = r_qa;
    assign o_data_b = r_qb;

endmodule

// File: src/eimc_exec.sv
module eimc_exec #(
    parameter int PC_WIDTH = eimc_pkg::PC_WIDTH_DEFAULT
) (
    input  logic [eimc_pkg::INSTR_W-1:0] i_instruction,
    input  logic [eimc_pkg::DATA_W-1:0]  i_op_a,
    input  logic [eimc_pkg::DATA_W-1:0]  i_op_b,
    input  logic [eimc_pkg::DATA_W-1:0]  i_sreg,
    input  logic [PC_WIDTH-1:0]          i_pc,
    output logic [PC_WIDTH-1:0]          o_next_pc,
    output eimc_pkg::t_out_item          o_res
);

    function automatic logic [5:0] pack_flags(input logic c, input logic [7:0] res,
                                              input logic v, input logic h);
        logic n;
        n = res[7];
        pack_flags = {h, n ^ v, v, n, res == 8'h00, c};
    endfunction

    logic [eimc_pkg::INSTR_W-1:0] ins;
    logic [7:0] sum;
    logic [7:0] diff;
    logic [5:0] add_f;
    logic [5:0] sub_f;
    logic [PC_WIDTH-1:0] pc_inc;
    logic [PC_WIDTH+11:0] rj_ext;
    logic [PC_WIDTH+6:0] br_ext;
    logic [PC_WIDTH+eimc_pkg::NEXT_PC_W-1:0] pc_ext;
    logic [PC_WIDTH-1:0] next_pc;
    logic [7:0] a;
    logic [7:0] b;

    assign ins    = i_instruction;
    assign a      = i_op_a;
    assign b      = i_op_b;
    assign sum    = a + b;
    assign diff   = a - b;
    assign pc_inc = i_pc + {{(PC_WIDTH-1){1'b0}}, 1'b1};
    assign rj_ext = {{PC_WIDTH{ins[11]}}, ins[11:0]};
    assign br_ext = {{PC_WIDTH{ins[9]}}, ins[9:3]};

    assign add_f = pack_flags(
        (a[7] & b[7]) | (b[7] & ~sum[7]) | (~sum[7] & a[7]),
        sum,
        (a[7] & b[7] & ~sum[7]) | (~a[7] & ~b[7] & sum[7]),
        (a[3] & b[3]) | (b[3] & ~sum[3]) | (~sum[3] & a[3]));

    assign sub_f = pack_flags(
        (~a[7] & b[7]) | (b[7] & diff[7]) | (diff[7] & ~a[7]),
        diff,
        (a[7] & ~b[7] & ~diff[7]) | (~a[7] & b[7] & diff[7]),
        (~a[3] & b[3]) | (b[3] & diff[3]) | (diff[3] & ~a[3]));

    always_comb begin
        next_pc              = pc_inc;
        o_res.status_flags   = i_sreg;
        o_res.write_index    = '0;
        o_res.write_data     = '0;
        o_res.write_done     = 1'b0;
        o_res.branch_taken   = 1'b0;
        o_res.unknown_opcode = 1'b0;
        if ((ins & eimc_pkg::MASK_TOP4) == eimc_pkg::PAT_LDI) begin
            o_res.write_index = {1'b1, ins[7:4]};
            o_res.write_data  = {ins[11:8], ins[3:0]};
            o_res.write_done  = 1'b1;
        end else if ((ins & eimc_pkg::MASK_ALU) == eimc_pkg::PAT_ADD) begin
            o_res.status_flags = {i_sreg[7:6], add_f};
            o_res.write_index  = ins[8:4];
            o_res.write_data   = sum;
            o_res.write_done   = 1'b1;
        end else if ((ins & eimc_pkg::MASK_ALU) == eimc_pkg::PAT_CP) begin
            o_res.status_flags = {i_sreg[7:6], sub_f};
        end else if ((ins & eimc_pkg::MASK_TOP4) == eimc_pkg::PAT_RJMP) begin
            next_pc            = pc_inc + rj_ext[PC_WIDTH-1:0];
            o_res.branch_taken = 1'b1;
        end else if ((ins & eimc_pkg::MASK_BR) == eimc_pkg::PAT_BR) begin
            if (i_sreg[eimc_pkg::FLAG_Z] == !ins[10]) begin
                next_pc            = pc_inc + br_ext[PC_WIDTH-1:0];
                o_res.branch_taken = 1'b1;
            end
        end else begin
            o_res.unknown_opcode = 1'b1;
        end
        pc_ext        = {{eimc_pkg::NEXT_PC_W{1'b0}}, next_pc};
        o_res.next_pc = pc_ext[eimc_pkg::NEXT_PC_W-1:0];
    end

    assign o_next_pc = next_pc;

endmodule

// File: src/eight_bit_mcu_instruction_core_unit.sv
// Channel    Dir  Payload       Contents
// i_item     in   t_in_item     instruction word at the current program counter
// o_result   out  t_out_item    next PC, flags, register write, branch, unknown flag
//
// One item per cycle is sustained unless the output stalls; results are registered in r_out.
// The register file reads both operands at acceptance into registered outputs.
// A write in the cycle of a dependent read is bypassed inside the register file.
// Reset clears the PC, the status register and the register file valid bits at once.
// A stalled output holds the execute stage, and the input stalls only when both are full.
module eight_bit_mcu_instruction_core_unit #(
    parameter int PC_WIDTH = eimc_pkg::PC_WIDTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    eimc_chan_if.sink          i_item,
    eimc_chan_if.source        o_result
);

    logic                              accept_in;
    logic                              s1_go;
    logic                              r_v1;
    logic [eimc_pkg::INSTR_W-1:0]      r_ins;
    logic                              r_ov;
    eimc_pkg::t_out_item               r_out;
    logic [eimc_pkg::DATA_W-1:0]       r_sreg;
    logic [PC_WIDTH-1:0]               r_pc;
    logic [eimc_pkg::DATA_W-1:0]       op_a;
    logic [eimc_pkg::DATA_W-1:0]       op_b;
    logic [PC_WIDTH-1:0]               exec_pc;
    eimc_pkg::t_out_item               exec_res;
    logic [eimc_pkg::INSTR_W-1:0]      in_ins;

    assign in_ins       = i_item.payload.instruction;
    assign accept_in    = i_item.valid & i_item.ready;
    assign s1_go        = r_v1 & (!r_ov | o_result.ready);
    assign i_item.ready = !r_v1 | s1_go;

    eimc_regfile u_rf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept_in),
        .i_addr_a (in_ins[8:4]),
        .i_addr_b ({in_ins[9], in_ins[3:0]}),
        .i_we     (s1_go & exec_res.write_done),
        .i_waddr  (exec_res.write_index),
        .i_wdata  (exec_res.write_data),
        .o_data_a (op_a),
        .o_data_b (op_b)
    );

    eimc_exec #(
        .PC_WIDTH (PC_WIDTH)
    ) u_exec (
        .i_instruction (r_ins),
        .i_op_a        (op_a),
        .i_op_b        (op_b),
        .i_sreg        (r_sreg),
        .i_pc          (r_pc),
        .o_next_pc     (exec_pc),
        .o_res         (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_ov   <= 1'b0;
            r_sreg <= '0;
            r_pc   <= '0;
        end else begin
            if (accept_in) begin
                r_v1 <= 1'b1;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end
            if (s1_go) begin
                r_ov   <= 1'b1;
                r_sreg <= exec_res.status_flags;
                r_pc   <= exec_pc;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_ins <= in_ins;
        end
        if (s1_go) begin
            r_out <= exec_res;
        end
    end

    assign o_result.valid   = r_ov;
    assign o_result.payload = r_out;

    a_hold_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !s1_go |=> r_v1 && $stable(r_ins))
        else $error("execute stage lost its item while stalled");

    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.unknown_opcode |-> !r_out.write_done && !r_out.branch_taken)
        else $error("unknown opcode wrote a register or branched");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_out.write_done |-> r_out.write_index == '0 && r_out.write_data == '0)
        else $error("write fields set without a register write");

    a_sreg_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sreg[7:6] == 2'b00)
        else $error("unused status bits became set");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_ov && r_out.status_flags == r_sreg)
        else $error("result flags differ from the status register");

endmodule
